// ===== rtl/dctf_pkg.sv =====
`default_nettype none
package dctf_pkg;

  localparam int LINE_BITS_DEF   = 24;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int OUT_BITS        = 24;
  localparam int CNT_BITS        = 6;
  localparam int CTX_BITS        = 6;

  localparam logic signed [CTX_BITS-1:0] CTX_RESET = 6'sd3;

  // input line kinds
  localparam logic [1:0] LK_EQUAL = 2'd0;

  // output entry kinds
  localparam logic [2:0] KIND_EQUAL = 3'd0;
  localparam logic [2:0] KIND_SKIP  = 3'd4;

  // One queued job: optional skip marker, then count equal lines that end
  // just before the final line, then the final line itself.
  typedef struct packed {
    logic [2:0]          kind;
    logic                skip;
    logic [CNT_BITS-1:0] count;
  } job_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/dctf_front.sv =====
`default_nettype none
module dctf_front #(
  parameter int LINE_BITS = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic signed [dctf_pkg::CTX_BITS-1:0]   ctx,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [1:0]                             line_kind,
  input  wire logic                                   list_start,
  input  wire logic                                   q_full,
  output logic                                        push,
  output dctf_pkg::job_ctl_t                          push_ctl,
  output logic [LINE_BITS-1:0]                        push_src,
  output logic [LINE_BITS-1:0]                        push_vis
);
  import dctf_pkg::*;

  logic [LINE_BITS-1:0] line_counter, line_counter_next;
  logic [LINE_BITS-1:0] equal_run, equal_run_next;
  logic                 change_seen, change_seen_next;
  logic [LINE_BITS-1:0] output_counter, output_counter_next;

  logic                 accept;
  logic                 emit;
  logic                 is_change;
  logic [LINE_BITS-1:0] lc, er, oc, er_inc, c_l, c2_l, g_minus_c;
  logic                 cs;
  logic [4:0]           c;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  // only an accepted item that gives entries becomes a job
  assign push     = accept & emit;

  always_comb begin
    lc        = list_start ? '0 : line_counter;
    er        = list_start ? '0 : equal_run;
    oc        = list_start ? '0 : output_counter;
    cs        = list_start ? 1'b0 : change_seen;
    is_change = line_kind != LK_EQUAL;
    c         = ctx[4:0];
    c_l       = LINE_BITS'(c);
    c2_l      = LINE_BITS'({c, 1'b0});
    er_inc    = (er == '1) ? er : er + 1'b1;
    g_minus_c = er - c_l;

    emit           = 1'b0;
    push_ctl.kind  = {1'b0, line_kind};
    push_ctl.skip  = 1'b0;
    push_ctl.count = '0;
    push_src       = lc;
    push_vis       = oc;

    line_counter_next   = lc + 1'b1;
    equal_run_next      = er;
    change_seen_next    = cs;
    output_counter_next = oc;

    if (ctx[CTX_BITS-1]) begin
      // pass every line through, keep counters current
      emit = 1'b1;
      output_counter_next = oc + 1'b1;
      if (is_change) begin
        equal_run_next   = '0;
        change_seen_next = 1'b1;
      end else begin
        equal_run_next = er_inc;
      end
    end else if (!is_change) begin
      equal_run_next = er_inc;
      if (cs && er_inc <= c_l) begin
        emit = 1'b1;
        output_counter_next = oc + 1'b1;
      end
    end else begin
      emit = 1'b1;
      if (er != '0) begin
        if (!cs) begin
          if (er < c2_l) begin
            push_ctl.count = er[CNT_BITS-1:0];
          end else begin
            push_ctl.skip  = 1'b1;
            push_ctl.count = CNT_BITS'(c);
          end
        end else begin
          if (er <= c2_l) begin
            if (er > c_l) push_ctl.count = g_minus_c[CNT_BITS-1:0];
          end else begin
            push_ctl.skip  = 1'b1;
            push_ctl.count = CNT_BITS'(c);
          end
        end
      end
      output_counter_next = oc + LINE_BITS'(push_ctl.skip)
                          + LINE_BITS'(push_ctl.count) + 1'b1;
      equal_run_next   = '0;
      change_seen_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_counter   <= '0;
      equal_run      <= '0;
      change_seen    <= 1'b0;
      output_counter <= '0;
    end else if (accept) begin
      line_counter   <= line_counter_next;
      equal_run      <= equal_run_next;
      change_seen    <= change_seen_next;
      output_counter <= output_counter_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dctf_queue.sv =====
`default_nettype none
module dctf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output logic                  not_empty,
  output logic                  full,
  output logic [$clog2(DEPTH+1)-1:0] fill
);
  import dctf_pkg::*;

  localparam int PTR_BITS = $clog2(DEPTH);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wptr, rptr;

  assign not_empty = fill != '0;
  assign full      = fill == ($clog2(DEPTH+1))'(DEPTH);
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_BITS'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PTR_BITS'(DEPTH-1)) ? '0 : rptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dctf_back.sv =====
`default_nettype none
module dctf_back #(
  parameter int LINE_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         head_valid,
  input  wire dctf_pkg::job_ctl_t           head_ctl,
  input  wire logic [LINE_BITS-1:0]         head_src,
  input  wire logic [LINE_BITS-1:0]         head_vis,
  output logic                              pop,
  output logic                              busy,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2:0]                        out_kind,
  output logic [dctf_pkg::OUT_BITS-1:0]     source_index,
  output logic [dctf_pkg::OUT_BITS-1:0]     visual_line,
  output logic                              last_of_run
);
  import dctf_pkg::*;

  logic                 skip_pend;
  logic [CNT_BITS-1:0]  remaining;
  logic [2:0]           cur_kind;
  logic [LINE_BITS-1:0] cur_src;
  logic [LINE_BITS-1:0] vis;
  logic [LINE_BITS-1:0] src_sel;
  logic                 take, done;

  always_comb begin
    if (skip_pend) begin
      out_kind    = KIND_SKIP;
      src_sel     = '0;
      last_of_run = 1'b0;
    end else if (remaining != '0) begin
      out_kind    = KIND_EQUAL;
      src_sel     = cur_src - LINE_BITS'(remaining);
      last_of_run = 1'b0;
    end else begin
      out_kind    = cur_kind;
      src_sel     = cur_src;
      last_of_run = 1'b1;
    end
  end

  assign out_valid    = busy;
  assign source_index = OUT_BITS'(src_sel);
  assign visual_line  = OUT_BITS'(vis);
  assign take         = busy & ~out_stall;
  assign done         = take & last_of_run;
  assign pop          = head_valid & (~busy | done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      skip_pend <= 1'b0;
      remaining <= '0;
    end else if (pop) begin
      busy      <= 1'b1;
      skip_pend <= head_ctl.skip;
      remaining <= head_ctl.count;
    end else if (take) begin
      if (done) busy <= 1'b0;
      if (skip_pend)              skip_pend <= 1'b0;
      else if (remaining != '0)   remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_kind <= head_ctl.kind;
      cur_src  <= head_src;
      vis      <= head_vis;
    end else if (take) begin
      vis <= vis + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/diff_context_trim_filter_unit.sv =====
// Diff context trim filter.
// Input channel (in_valid / in_stall): one diff line per item, line_kind
// plus list_start, which restarts numbering for a new list.
// Output channel (out_valid / out_stall): trimmed entries, each with its
// kind, original line index, visual line number and last_of_run on the
// final entry caused by one input item.
// Config channel (cfg_valid / cfg_ready): writes context_lines; ready is
// always high. Write only while the block is idle. Negative values pass
// every line through.
// An accepted item's job is queued and popped by the back once it is free.
// Throughput: the front takes one item per cycle while the job queue has
// room; the back emits one entry per cycle while out_stall is low, and an
// item can give up to 62 entries (after a long equal run).
// Items that give no entry never enter the queue.
// Reset clears the front's counters, empties the queue, drops any entry
// in flight and sets context_lines to 3.
// When out_stall is high the current entry holds; the queue fills and then
// in_stall rises.
`default_nettype none
module diff_context_trim_filter_unit #(
  parameter int LINE_BITS   = dctf_pkg::LINE_BITS_DEF,
  parameter int QUEUE_DEPTH = dctf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic signed [dctf_pkg::CTX_BITS-1:0] context_lines,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           line_kind,
  input  wire logic                                 list_start,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [2:0]                                out_kind,
  output logic [dctf_pkg::OUT_BITS-1:0]             source_index,
  output logic [dctf_pkg::OUT_BITS-1:0]             visual_line,
  output logic                                      last_of_run
);
  import dctf_pkg::*;

  localparam int JOB_BITS = $bits(job_ctl_t) + 2 * LINE_BITS;

  logic signed [CTX_BITS-1:0] ctx;

  logic                 push, pop, q_full, q_not_empty, back_busy;
  job_ctl_t             push_ctl, head_ctl;
  logic [LINE_BITS-1:0] push_src, push_vis, head_src, head_vis;
  logic [JOB_BITS-1:0]  head_job;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_fill;

  // Config register: always ready, hold between writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= CTX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ctx <= context_lines;
    end
  end

  // Front: classify each line and build a job for the back.
  dctf_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .ctx        (ctx),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .line_kind  (line_kind),
    .list_start (list_start),
    .q_full     (q_full),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_src   (push_src),
    .push_vis   (push_vis)
  );

  // Short job queue decouples classification from expansion.
  dctf_queue #(.WIDTH(JOB_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctl, push_src, push_vis}),
    .pop       (pop),
    .head      (head_job),
    .not_empty (q_not_empty),
    .full      (q_full),
    .fill      (q_fill)
  );

  assign {head_ctl, head_src, head_vis} = head_job;

  // Back: expand each job into skip, equal lines and the final line.
  dctf_back #(.LINE_BITS(LINE_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_not_empty),
    .head_ctl     (head_ctl),
    .head_src     (head_src),
    .head_vis     (head_vis),
    .pop          (pop),
    .busy         (back_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .source_index (source_index),
    .visual_line  (visual_line),
    .last_of_run  (last_of_run)
  );

  // An idle back always takes a waiting job on the next edge.
  a_back_picks_up: assert property (@(posedge clk) disable iff (rst)
    (!back_busy && q_not_empty) |=> back_busy)
    else $error("back left a queued job waiting");

  // A skip marker is always followed by at least the final line.
  a_skip_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_SKIP) |-> !last_of_run)
    else $error("skip marker closed a run");

  // Queue never overflows.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_fill <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("job queue overflow");

  // Nothing is pushed while the queue is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("push into full queue");

endmodule
`default_nettype wire
